// ----- rtl/sfc_pkg.sv -----
`timescale 1ns / 1ps
package sfc_pkg;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_BUILD = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// status codes of a read result
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_TOO_LONG = 2'd2;
	localparam logic [1:0] STAT_NO_RANK  = 2'd3;

	localparam int SYM_W       = 8;
	localparam int SYMS        = 256;
	localparam int IDX_W       = 9;   // counts 0..256
	localparam int LEN_W       = 7;
	localparam int CODE_W      = 64;
	localparam int COUNT_OUT_W = 24;
	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = 7;   // counts 0..64
	localparam int STACK_W     = 2 * SYM_W;

	typedef logic [SYM_W-1:0] sym_t;
	typedef logic [IDX_W-1:0] idx_t;

endpackage

// ----- rtl/shannon_fano_code_builder.sv -----
`timescale 1ns / 1ps
// Shannon-Fano code table builder. Add words (kind 0) are taken one per cycle:
// each is a read-modify-write of the histogram RAM with forwarding between
// back-to-back hits on the same byte. Clear (kind 1) zeroes the histogram
// through per-entry valid bits. Build (kind 2) runs an insertion sort into
// the ranked RAM (every byte value is scanned and each used symbol is
// inserted by shifting entries with smaller counts back), then splits ranges
// one RAM word per cycle: per range it sums the counts, searches the split
// point and then extends the codes. Read (kind 3) reads one ranked entry in
// S_RDOUT and registers it onto the output, holding the input off meanwhile;
// a read waits while an earlier result is still held on the output.
// Input is held off while a build or read is in progress.
module shannon_fano_code_builder #(
	parameter int ALPHABET     = 256,
	parameter int COUNT_WIDTH  = 24,
	parameter int MAX_CODE_LEN = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,  // data_byte[7:0], rank[15:8]
	input  logic [1:0]   s_tuser,  // req_type[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	// symbol[7:0], count[31:8], code_length[38:32], code_word[102:39],
	// used_symbols[111:103], status[113:112], zero fill [119:114]
	output logic [119:0] m_tdata
);

	localparam int SUM_W = COUNT_WIDTH + 9;
	localparam int CD_W  = sfc_pkg::LEN_W + sfc_pkg::CODE_W;
	localparam int RK_W  = COUNT_WIDTH + sfc_pkg::SYM_W;
	localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
	localparam logic [sfc_pkg::LEN_W-1:0] LMAX = sfc_pkg::LEN_W'(MAX_CODE_LEN);
	localparam logic [sfc_pkg::IDX_W-1:0] ALPH = sfc_pkg::IDX_W'(ALPHABET);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCAN_RD = 4'd1;
	localparam logic [3:0] S_SCAN_WT = 4'd2;
	localparam logic [3:0] S_INS     = 4'd3;
	localparam logic [3:0] S_PUT     = 4'd4;
	localparam logic [3:0] S_INIT    = 4'd5;
	localparam logic [3:0] S_LOOP    = 4'd6;
	localparam logic [3:0] S_POP     = 4'd7;
	localparam logic [3:0] S_SUM     = 4'd8;
	localparam logic [3:0] S_SPLIT   = 4'd9;
	localparam logic [3:0] S_FIX     = 4'd10;
	localparam logic [3:0] S_APP     = 4'd11;
	localparam logic [3:0] S_PUSH    = 4'd12;
	localparam logic [3:0] S_RDOUT   = 4'd13;

	logic [3:0] state_q;
	sfc_pkg::idx_t j_q, n_q, pos_q, used_q;
	logic [COUNT_WIDTH-1:0] cur_c_q;
	sfc_pkg::sym_t cur_b_q, lo_q, hi_q, m_q, idx_q, rank_q;
	logic [SUM_W-1:0] left_q, right_q;
	logic [sfc_pkg::SP_W-1:0] sp_q;
	logic built_q, ovf_q;
	logic [sfc_pkg::SYMS-1:0] hvalid_q;

	// add pipeline and forwarding
	logic s1_valid_s1;
	sfc_pkg::sym_t addr_s1;
	logic fwd_valid_q;
	sfc_pkg::sym_t fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;

	logic out_valid_q;
	logic [119:0] out_data_q;

	// memory ports
	logic h_we; sfc_pkg::sym_t h_raddr; logic [COUNT_WIDTH-1:0] h_wdata, h_rdata;
	logic rk_we; sfc_pkg::sym_t rk_waddr, rk_raddr; logic [RK_W-1:0] rk_wdata, rk_rdata;
	logic cd_we; sfc_pkg::sym_t cd_waddr, cd_raddr; logic [CD_W-1:0] cd_wdata, cd_rdata;
	logic st_we; logic [5:0] st_waddr, st_raddr;
	logic [sfc_pkg::STACK_W-1:0] st_wdata, st_rdata;

	sfc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(sfc_pkg::SYMS)) u_hist (
		.clk(clk), .we(h_we), .waddr(addr_s1), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata));
	sfc_ram #(.WIDTH(RK_W), .DEPTH(sfc_pkg::SYMS)) u_rank (
		.clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
		.raddr(rk_raddr), .rdata(rk_rdata));
	sfc_ram #(.WIDTH(CD_W), .DEPTH(sfc_pkg::SYMS)) u_code (
		.clk(clk), .we(cd_we), .waddr(cd_waddr), .wdata(cd_wdata),
		.raddr(cd_raddr), .rdata(cd_rdata));
	sfc_ram #(.WIDTH(sfc_pkg::STACK_W), .DEPTH(sfc_pkg::STACK_DEPTH)) u_stack (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata));

	// input decode
	logic acc;
	logic [1:0] req;
	sfc_pkg::sym_t in_byte, in_rank;
	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign req      = s_tuser;
	assign in_byte  = s_tdata[7:0];
	assign in_rank  = s_tdata[15:8];

	// histogram update for the add stage
	logic [COUNT_WIDTH-1:0] old_cnt;
	logic sat;
	always_comb begin
		if (fwd_valid_q && fwd_addr_q == addr_s1) begin
			old_cnt = fwd_data_q;
		end else if (hvalid_q[addr_s1]) begin
			old_cnt = h_rdata;
		end else begin
			old_cnt = '0;
		end
		sat     = (old_cnt == CMAX);
		h_we    = s1_valid_s1;
		h_wdata = sat ? old_cnt : old_cnt + 1'b1;
	end

	// build datapath helpers
	sfc_pkg::sym_t scan_b;
	logic [COUNT_WIDTH-1:0] scan_c, rk_c;
	sfc_pkg::sym_t rk_s;
	sfc_pkg::idx_t pos_dn;
	logic [SUM_W-1:0] left_dn, right_up;
	sfc_pkg::sym_t m_dn, m_fix;
	logic [sfc_pkg::LEN_W-1:0] ap_len;
	logic [sfc_pkg::CODE_W-1:0] ap_code;
	logic small_left;
	always_comb begin
		scan_b   = j_q[7:0] ^ 8'h80;
		scan_c   = hvalid_q[scan_b] ? h_rdata : '0;
		rk_c     = rk_rdata[RK_W-1:sfc_pkg::SYM_W];
		rk_s     = rk_rdata[sfc_pkg::SYM_W-1:0];
		pos_dn   = pos_q - 1'b1;
		left_dn  = left_q - SUM_W'(rk_c);
		right_up = right_q + SUM_W'(rk_c);
		m_dn     = m_q - 1'b1;
		m_fix    = (m_q >= hi_q) ? hi_q - 1'b1 : m_q;
		ap_len   = cd_rdata[CD_W-1:sfc_pkg::CODE_W];
		ap_code  = cd_rdata[sfc_pkg::CODE_W-1:0];
		small_left = ({1'b0, m_q} - {1'b0, lo_q}) <= ({1'b0, hi_q} - {1'b0, m_q} - 9'd1);
	end

	// memory control per state
	always_comb begin
		h_raddr  = in_byte;
		rk_we    = 1'b0; rk_waddr = pos_q[7:0]; rk_wdata = {cur_c_q, cur_b_q};
		rk_raddr = rank_q;
		cd_we    = 1'b0; cd_waddr = idx_q; cd_wdata = '0;
		cd_raddr = rank_q;
		st_we    = 1'b0; st_waddr = sp_q[5:0];
		st_wdata = {m_q + 1'b1, hi_q};
		st_raddr = sp_q[5:0] - 1'b1;
		unique case (state_q)
			S_IDLE: begin
				rk_raddr = in_rank;
				cd_raddr = in_rank;
			end
			S_SCAN_RD: h_raddr = scan_b;
			S_SCAN_WT: begin
				rk_raddr = pos_dn[7:0];
				rk_waddr = 8'd0;
				rk_wdata = {scan_c, scan_b};
				rk_we    = (scan_c != '0) && (n_q == '0);
				rk_raddr = n_q[7:0] - 1'b1;
			end
			S_INS: begin
				rk_we = 1'b1;
				if (rk_c < cur_c_q) begin
					rk_wdata = rk_rdata;
					rk_raddr = pos_dn[7:0] - 1'b1;
				end
			end
			S_PUT: rk_we = 1'b1;
			S_INIT: begin
				cd_we    = (j_q != n_q);
				cd_waddr = j_q[7:0];
			end
			S_LOOP: rk_raddr = lo_q;
			S_POP: ;
			S_SUM: rk_raddr = (idx_q < hi_q) ? idx_q + 1'b1 : hi_q - 1'b1;
			S_SPLIT: rk_raddr = m_dn - 1'b1;
			S_FIX: cd_raddr = lo_q;
			S_APP: begin
				cd_we    = 1'b1;
				cd_raddr = idx_q + 1'b1;
				if (ap_len < LMAX) begin
					cd_wdata = {ap_len + 1'b1, ap_code[sfc_pkg::CODE_W-2:0], idx_q > m_q};
				end else begin
					cd_wdata = {LMAX + 1'b1, ap_code};
				end
			end
			S_PUSH: begin
				st_we = (sp_q < sfc_pkg::SP_W'(sfc_pkg::STACK_DEPTH));
				if (!small_left) begin
					st_wdata = {lo_q, m_q};
				end
			end
			S_RDOUT: ;
			default: ;
		endcase
	end

	// read result
	logic [119:0] rd_word;
	logic [sfc_pkg::LEN_W-1:0] rd_len;
	logic [1:0] rd_stat;
	always_comb begin
		rd_len  = ap_len;
		rd_stat = ovf_q ? sfc_pkg::STAT_OVERFLOW : sfc_pkg::STAT_OK;
		if (ap_len > LMAX) begin
			rd_len  = LMAX;
			rd_stat = sfc_pkg::STAT_TOO_LONG;
		end
		if (!built_q || {1'b0, rank_q} >= used_q) begin
			rd_word = {6'd0, sfc_pkg::STAT_NO_RANK, used_q, 103'd0};
		end else begin
			rd_word = {6'd0, rd_stat, used_q, ap_code, rd_len,
				sfc_pkg::COUNT_OUT_W'(rk_c), rk_s};
		end
	end

	// control and build sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			j_q         <= '0;
			n_q         <= '0;
			pos_q       <= '0;
			used_q      <= '0;
			sp_q        <= '0;
			built_q     <= 1'b0;
			ovf_q       <= 1'b0;
			hvalid_q    <= '0;
			s1_valid_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_s1 <= acc && req == sfc_pkg::REQ_ADD && {1'b0, in_byte} < ALPH;
			fwd_valid_q <= h_we;
			if (h_we) begin
				hvalid_q[addr_s1] <= 1'b1;
				if (sat) begin
					ovf_q <= 1'b1;
				end
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (req)
							sfc_pkg::REQ_ADD: ;
							sfc_pkg::REQ_CLEAR: begin
								hvalid_q    <= '0;
								ovf_q       <= 1'b0;
								built_q     <= 1'b0;
								used_q      <= '0;
								fwd_valid_q <= 1'b0;
							end
							sfc_pkg::REQ_BUILD: begin
								j_q     <= '0;
								n_q     <= '0;
								state_q <= S_SCAN_RD;
							end
							sfc_pkg::REQ_READ: state_q <= S_RDOUT;
							default: ;
						endcase
					end
				end
				S_SCAN_RD: begin
					if (j_q[8]) begin
						j_q     <= '0;
						state_q <= S_INIT;
					end else if ({1'b0, scan_b} >= ALPH) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= S_SCAN_WT;
					end
				end
				S_SCAN_WT: begin
					cur_c_q <= scan_c;
					cur_b_q <= scan_b;
					pos_q   <= n_q;
					if (scan_c == '0) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_SCAN_RD;
					end else if (n_q == '0) begin
						n_q     <= n_q + 1'b1;
						j_q     <= j_q + 1'b1;
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (rk_c < cur_c_q) begin
						pos_q <= pos_dn;
						if (pos_dn == '0) begin
							state_q <= S_PUT;
						end
					end else begin
						n_q     <= n_q + 1'b1;
						j_q     <= j_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_PUT: begin
					n_q     <= n_q + 1'b1;
					j_q     <= j_q + 1'b1;
					state_q <= S_SCAN_RD;
				end
				S_INIT: begin
					if (j_q == n_q) begin
						used_q  <= n_q;
						built_q <= 1'b1;
						lo_q    <= '0;
						hi_q    <= n_q[7:0] - 1'b1;
						sp_q    <= '0;
						state_q <= (n_q < 9'd2) ? S_IDLE : S_LOOP;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_LOOP: begin
					if (lo_q < hi_q) begin
						left_q  <= '0;
						idx_q   <= lo_q;
						state_q <= S_SUM;
					end else if (sp_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						sp_q    <= sp_q - 1'b1;
						state_q <= S_POP;
					end
				end
				S_POP: begin
					lo_q    <= st_rdata[15:8];
					hi_q    <= st_rdata[7:0];
					state_q <= S_LOOP;
				end
				S_SUM: begin
					if (idx_q < hi_q) begin
						left_q <= left_q + SUM_W'(rk_c);
						idx_q  <= idx_q + 1'b1;
					end else begin
						right_q <= SUM_W'(rk_c);
						m_q     <= hi_q;
						state_q <= (left_q >= SUM_W'(rk_c)) ? S_SPLIT : S_FIX;
					end
				end
				S_SPLIT: begin
					left_q  <= left_dn;
					right_q <= right_up;
					m_q     <= m_dn;
					if (!(left_dn >= right_up && m_dn > lo_q)) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					m_q     <= m_fix;
					idx_q   <= lo_q;
					state_q <= S_APP;
				end
				S_APP: begin
					if (idx_q < hi_q) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (sp_q < sfc_pkg::SP_W'(sfc_pkg::STACK_DEPTH)) begin
						sp_q <= sp_q + 1'b1;
					end
					if (small_left) begin
						hi_q <= m_q;
					end else begin
						lo_q <= m_q + 1'b1;
					end
					state_q <= S_LOOP;
				end
				S_RDOUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= in_byte;
		if (h_we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= h_wdata;
		end
		if (acc) begin
			rank_q <= in_rank;
		end
		if (state_q == S_RDOUT && (!out_valid_q || m_tready)) begin
			out_data_q <= rd_word;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// checks
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= sfc_pkg::SP_W'(sfc_pkg::STACK_DEPTH))
		else $error("split stack pointer past depth");
	a_add_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 |-> $past(acc) && $past(req) == sfc_pkg::REQ_ADD)
		else $error("histogram update without an add word");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= ALPH)
		else $error("used symbol count past alphabet");

endmodule

// ----- rtl/sfc_ram.sv -----
`timescale 1ns / 1ps
// simple dual-port RAM, registered read (old data on same-address write)
module sfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
